// ===== hdl/rrcgs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrcgs_pkg: shared constants for the round-robin grant scheduler
// Default sizes, field widths and reset values used by the top level.
// ----------------------------------------------------------------------------
package rrcgs_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam int unsigned PID_BITS_DEF    = 16;

  // fixed widths of the stream fields
  localparam int unsigned PID_FIELD_BITS  = 16;
  localparam int unsigned SLICE_BITS      = 8;
  localparam int unsigned OUT_DATA_BITS   = 24;

  localparam logic [SLICE_BITS-1:0] SLICE_RESET = 8'd10;

endpackage

// ===== hdl/round_robin_cpu_grant_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// round_robin_cpu_grant_scheduler_top: round-robin grant scheduler
// Grants a run slot to one owner at a time, turns it over after a time slice
// and keeps waiting requesters in a ring queue.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one run request per beat: tdata holds the requester id,
//   tuser the finished flag. m_axis returns one result beat per request.
//   cfg_we_i / cfg_wdata_i write slice_length; write only while idle.
// Timing:
//   a request is taken only in the idle state; s_axis_tready drops for the
//   whole item. An owner or reserved-id request passes EXEC and OUT to the
//   output register, with TAKE between them when the queue head is popped. A
//   non-owner request scans the wait queue through the single registered
//   memory read port, one SCAN and one CMP step per queued entry, until its
//   id is found or the tail is reached. The next request is accepted the cycle
//   after the result is loaded.
// Reset:
//   rst_ni clears the queue pointers, makes the block idle (owner 0) and loads
//   slice counter and slice_length with 10. Queue entries need no clearing.
// Stall:
//   the result waits in the output register while m_axis_tready is low; a new
//   request can be taken meanwhile, its result is held until the register frees.
// ----------------------------------------------------------------------------
module round_robin_cpu_grant_scheduler_top #(
  parameter int unsigned QUEUE_DEPTH = rrcgs_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned PID_BITS    = rrcgs_pkg::PID_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration: slice_length
  input  logic                                  cfg_we_i,
  input  logic [rrcgs_pkg::SLICE_BITS-1:0]      cfg_wdata_i,
  // request stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [rrcgs_pkg::PID_FIELD_BITS-1:0]  s_axis_tdata,  // [15:0] requester_pid
  input  logic                                  s_axis_tuser,  // [0] is_finished
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [0] granted, [1] turned_over, [17:2] running_pid, [18] queue_dropped, [23:19] zero
  output logic [rrcgs_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_TAKE = 6'b000100,
    S_SCAN = 6'b001000,
    S_CMP  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  state_e state_q, state_d;
  logic [PID_BITS-1:0] pid_q, pid_d;
  logic                fin_q, fin_d;
  logic [PID_BITS-1:0] owner_q, owner_d;
  logic [rrcgs_pkg::SLICE_BITS-1:0] slice_left_q, slice_left_d;
  logic [rrcgs_pkg::SLICE_BITS-1:0] slice_len_q;
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d, scan_q, scan_d;
  logic append_q, append_d;
  logic granted_q, granted_d, turned_q, turned_d, dropped_q, dropped_d;
  logic out_valid_q, out_valid_d;
  logic [rrcgs_pkg::OUT_DATA_BITS-1:0] out_data_q, out_data_d;

  // wait queue memory
  logic [PID_BITS-1:0] queue_mem [QUEUE_DEPTH];
  logic [PID_BITS-1:0] rdata_q;
  logic [PtrW-1:0]     raddr, waddr;
  logic                mem_we;

  logic q_empty, q_full;
  logic [rrcgs_pkg::PID_FIELD_BITS-1:0] running16;

  assign q_empty   = (head_q == tail_q);
  assign q_full    = (ring_next(tail_q) == head_q);
  assign waddr     = ring_next(tail_q);
  assign running16 = rrcgs_pkg::PID_FIELD_BITS'(owner_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      queue_mem[waddr] <= pid_q;
    end
    rdata_q <= queue_mem[raddr];
  end

  always_comb begin
    state_d      = state_q;
    pid_d        = pid_q;
    fin_d        = fin_q;
    owner_d      = owner_q;
    slice_left_d = slice_left_q;
    head_d       = head_q;
    tail_d       = tail_q;
    scan_d       = scan_q;
    append_d     = append_q;
    granted_d    = granted_q;
    turned_d     = turned_q;
    dropped_d    = dropped_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    mem_we       = 1'b0;
    raddr        = ring_next(head_q);

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          pid_d   = PID_BITS'(s_axis_tdata);
          fin_d   = s_axis_tuser;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        granted_d = 1'b0;
        turned_d  = 1'b0;
        dropped_d = 1'b0;
        state_d   = S_OUT;
        if (pid_q != '0) begin
          if (owner_q == '0) begin
            owner_d = pid_q;
          end
          if (owner_q == '0 || owner_q == pid_q) begin
            if (fin_q) begin
              granted_d    = 1'b1;
              slice_left_d = slice_len_q;
              if (q_empty) begin
                owner_d = '0;
              end else begin
                // head read issued this cycle, its data becomes the new owner in S_TAKE
                head_d   = ring_next(head_q);
                append_d = 1'b0;
                state_d  = S_TAKE;
              end
            end else if (slice_left_q == '0) begin
              turned_d     = 1'b1;
              slice_left_d = slice_len_q;
              if (!q_empty) begin
                head_d   = ring_next(head_q);
                append_d = 1'b1;
                state_d  = S_TAKE;
              end
            end else begin
              granted_d    = 1'b1;
              slice_left_d = slice_left_q - 1'b1;
            end
          end else begin
            scan_d  = head_q;
            state_d = S_SCAN;
          end
        end
      end
      S_TAKE: begin
        owner_d = rdata_q;
        if (append_q) begin
          // old owner is appended at the tail after the head pop, cannot overflow
          mem_we = 1'b1;
          tail_d = ring_next(tail_q);
        end
        state_d = S_OUT;
      end
      S_SCAN: begin
        raddr = ring_next(scan_q);
        if (scan_q == tail_q) begin
          if (q_full) begin
            dropped_d = 1'b1;
          end else begin
            mem_we = 1'b1;
            tail_d = ring_next(tail_q);
          end
          state_d = S_OUT;
        end else begin
          scan_d  = ring_next(scan_q);
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d = (rdata_q == pid_q) ? S_OUT : S_SCAN;
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {5'b0, dropped_q, running16, turned_q, granted_q};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      owner_q      <= '0;
      slice_left_q <= rrcgs_pkg::SLICE_RESET;
      slice_len_q  <= rrcgs_pkg::SLICE_RESET;
      head_q       <= '0;
      tail_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      owner_q      <= owner_d;
      slice_left_q <= slice_left_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        slice_len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pid_q      <= pid_d;
    fin_q      <= fin_d;
    scan_q     <= scan_d;
    append_q   <= append_d;
    granted_q  <= granted_d;
    turned_q   <= turned_d;
    dropped_q  <= dropped_d;
    out_data_q <= out_data_d;
  end

`ifndef ASSERT_OFF
  // one item in flight: no request is taken right after one was accepted
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while an item is in flight");

  // a grant and a turnover never come together
  a_grant_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("granted and turned_over both set");

  // a dropped append only happens on a plain non-owner request
  a_drop_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[18]) |-> (!m_axis_tdata[0] && !m_axis_tdata[1]))
    else $error("queue_dropped with grant or turnover");

  // the queue is never written past its head
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !(q_full && state_q == S_SCAN))
    else $error("append into a full queue");
`endif

endmodule
